FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/ppmq_pkg.sv
`default_nettype none
package ppmq_pkg;

  localparam int DEPTH  = 1024;
  localparam int DATA_W = 64;
  localparam int WORD_W = 64;
  localparam int CNT_W  = 11;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int ADDR_W = IDX_W + 1;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_SWAP  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } ppmq_op_t;

  typedef enum logic [2:0] {
    ST_PUSH_FULL  = 3'd0,
    ST_PUSH_FIRST = 3'd1,
    ST_PUSH_MORE  = 3'd2,
    ST_SWAPPED    = 3'd3,
    ST_NO_SWAP    = 3'd4,
    ST_POPPED     = 3'd5,
    ST_POP_EMPTY  = 3'd6,
    ST_CLEARED    = 3'd7
  } ppmq_status_t;

  typedef logic [CNT_W-1:0] ppmq_cnt_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ppmq_ram_req_t;

  typedef struct packed {
    ppmq_status_t status;
    logic         popped;
    ppmq_cnt_t    fill_count;
    logic         fill_empty;
    logic         fill_full;
  } ppmq_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/ppmq_in_if.sv
`default_nettype none
interface ppmq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] push_data;

  modport source (output valid, output op, output push_data, input ready);
  modport sink   (input valid, input op, input push_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ppmq_out_if.sv
`default_nettype none
interface ppmq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] pop_data;
  logic [10:0] fill_count;
  logic        fill_empty;
  logic        fill_full;

  modport source (output valid, output status, output pop_data, output fill_count,
                  output fill_empty, output fill_full, input ready);
  modport sink   (input valid, input status, input pop_data, input fill_count,
                  input fill_empty, input fill_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ppmq_cfg_if.sv
`default_nettype none
interface ppmq_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ppmq_ram.sv
`default_nettype none
module ppmq_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ppmq_ctrl.sv
`default_nettype none
module ppmq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic [63:0]           in_push_data,
  input  wire logic                  cfg_valid,
  input  wire logic [10:0]           cfg_data,
  output ppmq_pkg::ppmq_ram_req_t    ram_req,
  output logic                       s1_valid,
  output ppmq_pkg::ppmq_res_t        s1_res,
  input  wire logic                  s1_take
);
  import ppmq_pkg::*;

  logic      bank_sel_r, bank_sel_nxt;
  ppmq_cnt_t fill_r, fill_nxt;
  ppmq_cnt_t drain_idx_r, drain_idx_nxt;
  ppmq_cnt_t drain_cnt_r, drain_cnt_nxt;
  ppmq_cnt_t cap_r;
  ppmq_cnt_t cap_eff;
  ppmq_cnt_t drain_idx_inc;
  logic      s1_valid_r, s1_valid_nxt;
  ppmq_res_t s1_res_r, s1_res_nxt;
  logic      accept;

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_valid && in_ready;
  assign cap_eff  = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;
  assign drain_idx_inc = drain_idx_r + CNT_W'(1);

  always_comb begin
    bank_sel_nxt  = bank_sel_r;
    fill_nxt      = fill_r;
    drain_idx_nxt = drain_idx_r;
    drain_cnt_nxt = drain_cnt_r;
    s1_res_nxt    = s1_res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = {bank_sel_r, fill_r[IDX_W-1:0]};
    ram_req.wdata = DATA_W'(in_push_data);
    ram_req.re    = 1'b0;
    ram_req.raddr = {~bank_sel_r, drain_idx_r[IDX_W-1:0]};
    if (accept) begin
      s1_res_nxt.popped = 1'b0;
      case (ppmq_op_t'(in_op))
        OP_PUSH: begin
          if (fill_r >= cap_eff) begin
            s1_res_nxt.status = ST_PUSH_FULL;
          end else begin
            ram_req.we = 1'b1;
            fill_nxt   = fill_r + CNT_W'(1);
            s1_res_nxt.status = (fill_r == '0) ? ST_PUSH_FIRST : ST_PUSH_MORE;
          end
        end
        OP_SWAP: begin
          if (fill_r == '0) begin
            s1_res_nxt.status = ST_NO_SWAP;
          end else begin
            bank_sel_nxt  = ~bank_sel_r;
            drain_cnt_nxt = fill_r;
            drain_idx_nxt = '0;
            fill_nxt      = '0;
            s1_res_nxt.status = ST_SWAPPED;
          end
        end
        OP_POP: begin
          if (drain_cnt_r == '0 || drain_idx_r >= CNT_W'(DEPTH)) begin
            drain_cnt_nxt = '0;
            drain_idx_nxt = '0;
            s1_res_nxt.status = ST_POP_EMPTY;
          end else begin
            ram_req.re        = 1'b1;
            s1_res_nxt.popped = 1'b1;
            s1_res_nxt.status = ST_POPPED;
            if (drain_idx_inc >= drain_cnt_r) begin
              drain_idx_nxt = '0;
              drain_cnt_nxt = '0;
            end else begin
              drain_idx_nxt = drain_idx_inc;
            end
          end
        end
        default: begin
          fill_nxt = '0;
          s1_res_nxt.status = ST_CLEARED;
        end
      endcase
      s1_res_nxt.fill_count = fill_nxt;
      s1_res_nxt.fill_empty = (fill_nxt == '0);
      s1_res_nxt.fill_full  = (fill_nxt == cap_eff);
    end
  end

  assign s1_valid_nxt = accept || (s1_valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r  <= 1'b0;
      fill_r      <= '0;
      drain_idx_r <= '0;
      drain_cnt_r <= '0;
      cap_r       <= CAP_RESET;
      s1_valid_r  <= 1'b0;
    end else begin
      bank_sel_r  <= bank_sel_nxt;
      fill_r      <= fill_nxt;
      drain_idx_r <= drain_idx_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r <= s1_res_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_res   = s1_res_r;

endmodule
`default_nettype wire

FILE: rtl/core/ping_pong_message_queue_core.sv
// Ping-pong message queue: two banks of 1024 words in one 2048-word synchronous RAM. Pushes
// append to the fill bank until the capacity register is reached, a swap hands the fill bank
// to the drain side (dropping anything still undrained there), pops read the drain bank in
// push order, and clear empties the fill side only. The block accepts one request per clock
// cycle while the control stage is free or moving on; each request gives exactly one result,
// held first in the control stage, where the registered read of the bank RAM lands, and then
// in the output register. Results wait there, so a stall at the output only backs up the input
// once the control stage is also full. The RAM needs no clearing pass after reset: a pop only
// ever reads entries pushed before the swap that handed its bank to the drain side.
`default_nettype none
module ping_pong_message_queue_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ppmq_in_if.sink     in_chan,
  ppmq_out_if.source  out_chan,
  ppmq_cfg_if.sink    cfg_chan
);
  import ppmq_pkg::*;

  ppmq_ram_req_t     ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              s1_valid;
  ppmq_res_t         s1_res;
  logic              s1_take;
  logic              out_valid_r, out_valid_nxt;
  ppmq_res_t         out_res_r;
  logic [WORD_W-1:0] out_data_r;

  // The capacity register takes every write; software must write it only while idle, unchecked.
  assign cfg_chan.ready = 1'b1;

  ppmq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_op        (in_chan.op),
    .in_push_data (in_chan.push_data),
    .cfg_valid    (cfg_chan.valid),
    .cfg_data     (cfg_chan.data),
    .ram_req      (ram_req),
    .s1_valid     (s1_valid),
    .s1_res       (s1_res),
    .s1_take      (s1_take)
  );

  ppmq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // The RAM read data belonging to the control stage is valid alongside it and holds while
  // that stage stalls, because no new read is issued until the stage moves on.
  assign s1_take       = s1_valid && (!out_valid_r || out_chan.ready);
  assign out_valid_nxt = s1_take || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_res_r  <= s1_res;
      out_data_r <= s1_res.popped ? WORD_W'(ram_rdata) : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_res_r.status;
  assign out_chan.pop_data   = out_data_r;
  assign out_chan.fill_count = out_res_r.fill_count;
  assign out_chan.fill_empty = out_res_r.fill_empty;
  assign out_chan.fill_full  = out_res_r.fill_full;

endmodule
`default_nettype wire

FILE: rtl/core/ppmq_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ppmq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [63:0] pop_data,
  input wire logic [10:0] fill_count,
  input wire logic        fill_empty
);
  import ppmq_pkg::*;

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status), "stall lost")
  `ASSERT_NEVER(a_pop_data_zero, out_valid && status != ST_POPPED && pop_data != '0, "stray data")
  `ASSERT_NEVER(a_empty_flag, out_valid && (fill_empty != (fill_count == '0)), "empty flag wrong")
  `ASSERT_NEVER(a_first_push, out_valid && status == ST_PUSH_FIRST && fill_count != 11'd1, "bad count")
  `ASSERT_NEVER(a_swap_clears, out_valid && (status == ST_SWAPPED || status == ST_CLEARED) && !fill_empty, "not empty")

endmodule

bind ping_pong_message_queue_core ppmq_checker u_ppmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .status     (out_chan.status),
  .pop_data   (out_chan.pop_data),
  .fill_count (out_chan.fill_count),
  .fill_empty (out_chan.fill_empty)
);
`default_nettype wire
